[rtl/core/stbs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared constants and types of the sorted-table binary search block.
// ----------------------------------------------------------------------------
package stbs_pkg;

  localparam int TABLE_DEPTH   = 1024;
  localparam int ELEMENT_WIDTH = 32;
  localparam int ADDR_W        = $clog2(TABLE_DEPTH);
  localparam int POS_W         = 10;
  localparam int KEY_W         = 32;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef logic [POS_W-1:0] pos_t;

  // one input beat as seen by the sequencer
  typedef struct packed {
    logic               cmd;
    pos_t               slot;
    logic signed [KEY_W-1:0] element;
    logic signed [KEY_W-1:0] key;
    pos_t               range_first;
    pos_t               range_last;
  } item_t;

  // one finished search result
  typedef struct packed {
    logic found;
    pos_t position;
    logic range_error;
  } res_t;

  // slot lies inside the table
  function automatic logic in_table(input pos_t s);
    in_table = (32'(s) < TABLE_DEPTH);
  endfunction

  // probe point of an inclusive range, lo <= hi
  function automatic pos_t mid_of(input pos_t lo, input pos_t hi);
    pos_t d;
    d = hi - lo;
    mid_of = lo + (d >> 1);
  endfunction

  // element as stored, keeping its sign
  function automatic logic signed [ELEMENT_WIDTH-1:0] to_elem(
      input logic signed [KEY_W-1:0] v);
    to_elem = ELEMENT_WIDTH'(v);
  endfunction

endpackage

[rtl/core/sorted_table_binary_search.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// Sorted table of signed values with binary search and deferred equality.
// ----------------------------------------------------------------------------
// the table sits in one single-port ram of TABLE_DEPTH entries with a
// registered read. a write beat (cmd 0) stores one element and gives no
// result; a slot past the table is dropped. a search beat (cmd 1) probes
// the ram once per cycle, halving the range on a less-than test only, then
// checks equality on the last slot: it issues the first read, probes until
// the range holds one slot, checks that slot and hands the result off. a
// reversed range or one past the table returns range_error. the block
// takes one beat at a time; a finished result sits in the output register,
// so the next beat is taken while it waits. entries never written read as
// garbage; fill the table in ascending order before searching it.
// ----------------------------------------------------------------------------
module sorted_table_binary_search
  import stbs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  // input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_cmd,
  input  logic [POS_W-1:0]        in_slot,
  input  logic signed [KEY_W-1:0] in_element,
  input  logic signed [KEY_W-1:0] in_key,
  input  logic [POS_W-1:0]        in_range_first,
  input  logic [POS_W-1:0]        in_range_last,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_found,
  output logic [POS_W-1:0]        out_position,
  output logic                    out_range_error
);

  item_t item;
  res_t  res;
  logic  res_valid;
  logic  res_take;

  // output register state
  logic  out_valid_r, out_valid_nxt;
  res_t  out_r, out_nxt;

  assign item = '{cmd:         in_cmd,
                  slot:        in_slot,
                  element:     in_element,
                  key:         in_key,
                  range_first: in_range_first,
                  range_last:  in_range_last};

  stbs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_valid),
    .item_stall (in_stall),
    .item       (item),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res)
  );

  // result moves into the output register when it is empty or draining
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_r.found;
  assign out_position    = out_r.position;
  assign out_range_error = out_r.range_error;

endmodule

[rtl/core/stbs_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/stbs_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_ctrl
// Search sequencer: one table probe per cycle, final equality check.
// ----------------------------------------------------------------------------
module stbs_ctrl
  import stbs_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  item_valid,
  output logic  item_stall,
  input  item_t item,
  output logic  res_valid,
  input  logic  res_take,
  output res_t  res
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_r, state_nxt;
  pos_t       lo_r, lo_nxt;
  pos_t       hi_r, hi_nxt;
  pos_t       mid_r, mid_nxt;
  logic signed [ELEMENT_WIDTH-1:0] key_r, key_nxt;
  res_t       res_r, res_nxt;

  logic                     mem_en;
  logic                     mem_we;
  logic [ADDR_W-1:0]        mem_addr;
  logic [ELEMENT_WIDTH-1:0] mem_rdata;
  logic signed [ELEMENT_WIDTH-1:0] rd_elem;

  logic accept;
  logic bad_range;
  logic cmp_lt;
  pos_t lo_step, hi_step;

  stbs_ram #(
    .WIDTH (ELEMENT_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (to_elem(item.element)),
    .rdata (mem_rdata)
  );

  assign item_stall = (state_r != S_IDLE);
  assign accept     = item_valid && (state_r == S_IDLE);
  assign bad_range  = (item.range_first > item.range_last) || !in_table(item.range_last);
  assign rd_elem    = $signed(mem_rdata);
  assign cmp_lt     = (rd_elem < key_r);
  assign lo_step    = cmp_lt ? (mid_r + pos_t'(1)) : lo_r;
  assign hi_step    = cmp_lt ? hi_r : mid_r;
  assign res_valid  = (state_r == S_DONE);
  assign res        = res_r;

  always_comb begin
    state_nxt = state_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    key_nxt   = key_r;
    res_nxt   = res_r;
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = ADDR_W'(item.slot);
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (item.cmd == CMD_WRITE) begin
            mem_en = in_table(item.slot);
            mem_we = 1'b1;
          end else if (bad_range) begin
            res_nxt   = '{found: 1'b0, position: '0, range_error: 1'b1};
            state_nxt = S_DONE;
          end else begin
            key_nxt = to_elem(item.key);
            lo_nxt  = item.range_first;
            hi_nxt  = item.range_last;
            mem_en  = 1'b1;
            if (item.range_first < item.range_last) begin
              mid_nxt   = mid_of(item.range_first, item.range_last);
              mem_addr  = ADDR_W'(mid_nxt);
              state_nxt = S_CMP;
            end else begin
              mem_addr  = ADDR_W'(item.range_first);
              state_nxt = S_FIN;
            end
          end
        end
      end
      S_CMP: begin
        lo_nxt = lo_step;
        hi_nxt = hi_step;
        mem_en = 1'b1;
        if (lo_step < hi_step) begin
          mid_nxt  = mid_of(lo_step, hi_step);
          mem_addr = ADDR_W'(mid_nxt);
        end else begin
          mem_addr  = ADDR_W'(lo_step);
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        res_nxt.range_error = 1'b0;
        res_nxt.found       = (rd_elem == key_r);
        res_nxt.position    = (rd_elem == key_r) ? lo_r : '0;
        state_nxt           = S_DONE;
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    mid_r <= mid_nxt;
    key_r <= key_nxt;
    res_r <= res_nxt;
  end

  // range never inverts while narrowing
  a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP || state_r == S_FIN) |-> (lo_r <= hi_r))
    else $error("search range inverted");

  // probe point lies inside the live range
  a_mid_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (mid_r >= lo_r && mid_r < hi_r))
    else $error("probe outside range");

  // final check sees a single slot
  a_fin_single: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> (lo_r == hi_r))
    else $error("final check on open range");

  // table written only between searches
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_en && mem_we) |-> ($past(state_r) != S_CMP || state_r == S_IDLE))
    else $error("table write during search");

  // error result carries no match
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.range_error) |-> (!res.found && res.position == '0))
    else $error("range error with match");

endmodule

[test/sorted_table_binary_search_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_binary_search_test
// Self-checking bench for the sorted-table binary search block. A short
// directed table covers reversed ranges, the extreme values and duplicate
// keys. The lower half of the table is then filled in ascending order, and
// random beats follow: sorted rewrites of short runs, a few stray writes that
// break the order, and searches over mostly short spans inside the filled
// half with keys mostly taken from the table.
// Every search result is compared field by field with the answer a directed
// row carries or with a local model of the probe sequence, under several
// sender and receiver idling patterns and one long receiver hold-off.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_test;
  import stbs_pkg::*;

  localparam logic signed [KEY_W-1:0] ELEM_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] ELEM_MAX = {1'b0, {(KEY_W-1){1'b1}}};
  // slots filled in ascending order; random searches other than reversed ranges stay below this
  localparam int LIVE_SLOTS = TABLE_DEPTH / 2;
  localparam int PHASE_BEATS = 56;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 40;

  // one row of the directed table; typed rows carry their own answer
  typedef struct {
    item_t beat;
    bit    typed;
    res_t  answer;
  } probe_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_cmd = CMD_WRITE;
  logic [POS_W-1:0]  in_slot = '0;
  logic signed [KEY_W-1:0] in_element = '0;
  logic signed [KEY_W-1:0] in_key = '0;
  logic [POS_W-1:0]  in_range_first = '0;
  logic [POS_W-1:0]  in_range_last = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_found;
  logic [POS_W-1:0]  out_position;
  logic              out_range_error;

  // local copy of the table, kept in step with every accepted write beat
  logic signed [ELEMENT_WIDTH-1:0] mirror_mem [TABLE_DEPTH];
  res_t pending_answers[$];
  int   mismatches = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  // toggled to ask the receiver process for one long hold-off
  bit   hold_req = 1'b0;
  bit   hold_seen = 1'b0;
  int   hold_left = 0;

  always #10 clk = ~clk;

  sorted_table_binary_search i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_slot         (in_slot),
    .in_element      (in_element),
    .in_key          (in_key),
    .in_range_first  (in_range_first),
    .in_range_last   (in_range_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_found       (out_found),
    .out_position    (out_position),
    .out_range_error (out_range_error)
  );

  // --------------------------------------------------------------------------
  // prediction: the same halving on less-than, equality checked once at the
  // end, so in a sorted range a hit lands on the lowest slot holding the key
  // --------------------------------------------------------------------------
  function automatic res_t search_answer(input item_t b);
    res_t r;
    int unsigned lo, hi, mid;
    logic signed [ELEMENT_WIDTH-1:0] k;
    r  = '0;
    lo = b.range_first;
    hi = b.range_last;
    k  = b.key;
    if (lo > hi || hi >= TABLE_DEPTH) begin
      r.range_error = 1'b1;
    end else begin
      while (lo < hi) begin
        mid = lo + ((hi - lo) >> 1);
        if (mirror_mem[mid] < k) begin
          lo = mid + 1;
        end else begin
          hi = mid;
        end
      end
      if (mirror_mem[lo] == k) begin
        r.found    = 1'b1;
        r.position = pos_t'(lo);
      end
    end
    return r;
  endfunction

  // every field random, so unused fields of a beat toggle as well
  function automatic item_t noise_beat();
    item_t b;
    b.cmd         = 1'($urandom);
    b.slot        = pos_t'($urandom);
    b.element     = $urandom;
    b.key         = $urandom;
    b.range_first = pos_t'($urandom);
    b.range_last  = pos_t'($urandom);
    return b;
  endfunction

  function automatic probe_row_t write_row(input pos_t s, input logic signed [KEY_W-1:0] v);
    probe_row_t r;
    r.beat         = '0;
    r.beat.cmd     = CMD_WRITE;
    r.beat.slot    = s;
    r.beat.element = v;
    r.typed        = 1'b0;
    r.answer       = '0;
    return r;
  endfunction

  function automatic probe_row_t search_row(input pos_t first, input pos_t last,
                                            input logic signed [KEY_W-1:0] k);
    probe_row_t r;
    r.beat             = '0;
    r.beat.cmd         = CMD_SEARCH;
    r.beat.key         = k;
    r.beat.range_first = first;
    r.beat.range_last  = last;
    r.typed            = 1'b0;
    r.answer           = '0;
    return r;
  endfunction

  function automatic probe_row_t checked_row(input pos_t first, input pos_t last,
                                             input logic signed [KEY_W-1:0] k,
                                             input logic hit, input pos_t at,
                                             input logic bad_range);
    probe_row_t r;
    r = search_row(first, last, k);
    r.typed              = 1'b1;
    r.answer.found       = hit;
    r.answer.position    = at;
    r.answer.range_error = bad_range;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // sender: optional idle cycles, then hold the beat until it is taken
  // --------------------------------------------------------------------------
  task automatic drive_beat(input item_t b, input bit typed, input res_t typed_answer);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_cmd         <= b.cmd;
    in_slot        <= b.slot;
    in_element     <= b.element;
    in_key         <= b.key;
    in_range_first <= b.range_first;
    in_range_last  <= b.range_last;
    do @(posedge clk); while (in_stall);
    // beat taken at this edge: update the copy or queue the answer
    if (b.cmd == CMD_WRITE) begin
      if (32'(b.slot) < TABLE_DEPTH) mirror_mem[b.slot] = b.element;
    end else begin
      pending_answers.push_back(typed ? typed_answer : search_answer(b));
    end
  endtask

  task automatic send_plain(input item_t b);
    drive_beat(b, 1'b0, '0);
  endtask

  // rewrite a short run of filled slots with sorted values that fit between
  // the neighbors, with runs of duplicates now and then
  task automatic rewrite_run(output int n);
    int unsigned start;
    int          vals[$];
    longint      low_v, high_v, span_v, t;
    longint unsigned r;
    item_t       b;
    start = $urandom_range(LIVE_SLOTS - 1);
    n = $urandom_range(1, 16);
    if (start + n > LIVE_SLOTS) n = LIVE_SLOTS - start;
    low_v  = (start > 0) ? longint'(mirror_mem[start-1]) : longint'(ELEM_MIN);
    high_v = (start + n < LIVE_SLOTS) ? longint'(mirror_mem[start+n]) : longint'(ELEM_MAX);
    if (low_v > high_v) begin
      t = low_v;
      low_v = high_v;
      high_v = t;
    end
    span_v = high_v - low_v + 1;
    for (int i = 0; i < n; i++) begin
      r = {$urandom, $urandom};
      if (i > 0 && $urandom_range(99) < 30) begin
        vals.push_back(vals[i-1]);
      end else begin
        vals.push_back(int'(low_v + longint'(r % longint'(span_v))));
      end
    end
    vals.sort();
    for (int i = 0; i < n; i++) begin
      b         = noise_beat();
      b.cmd     = CMD_WRITE;
      b.slot    = pos_t'(start + i);
      b.element = vals[i];
      send_plain(b);
    end
  endtask

  // one search beat: mostly short spans, keys mostly taken from the table
  task automatic random_search();
    item_t b;
    int unsigned first, last, pick;
    int roll;
    b     = noise_beat();
    b.cmd = CMD_SEARCH;
    roll  = $urandom_range(99);
    if (roll < 8) begin
      first = $urandom_range(1, TABLE_DEPTH - 1);
      last  = $urandom_range(first - 1);
    end else if (roll < 13) begin
      first = 0;
      last  = LIVE_SLOTS - 1;
    end else if (roll < 85) begin
      first = $urandom_range(LIVE_SLOTS - 1);
      last  = first + $urandom_range(31);
      if (last > LIVE_SLOTS - 1) last = LIVE_SLOTS - 1;
    end else begin
      first = $urandom_range(LIVE_SLOTS - 1);
      last  = $urandom_range(first, LIVE_SLOTS - 1);
    end
    b.range_first = pos_t'(first);
    b.range_last  = pos_t'(last);
    if (first <= last) begin
      pick = $urandom_range(first, last);
      roll = $urandom_range(99);
      if (roll < 50)      b.key = mirror_mem[pick];
      else if (roll < 60) b.key = mirror_mem[pick] + 1;
      else if (roll < 70) b.key = mirror_mem[pick] - 1;
      else if (roll < 75) b.key = ($urandom_range(1) != 0) ? ELEM_MAX : ELEM_MIN;
    end
    send_plain(b);
  endtask

  // --------------------------------------------------------------------------
  // receiver: random stall, or one long hold-off when asked
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  // result checker: each result beat against the oldest queued answer
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        $error("result beat with no search pending: found %0d position %0d range_error %0d",
               out_found, out_position, out_range_error);
        mismatches++;
      end else begin
        want = pending_answers.pop_front();
        if (out_found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_found);
          mismatches++;
        end
        if (out_position !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, out_position);
          mismatches++;
        end
        if (out_range_error !== want.range_error) begin
          $error("range_error: expected %0d, got %0d", want.range_error, out_range_error);
          mismatches++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    probe_row_t rows[$];
    int phase_send[5];
    int phase_recv[5];
    int sent, n, roll;
    longint level;
    item_t b;

    phase_send = '{0, 86, 0, 21, 0};
    phase_recv = '{0, 0, 86, 21, 0};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reversed ranges straight after reset: no table read at all
    rows.push_back(checked_row(1, 0, 0, 1'b0, 0, 1'b1));
    rows.push_back(checked_row(pos_t'(TABLE_DEPTH - 1), 0, ELEM_MAX, 1'b0, 0, 1'b1));
    // a few slots at both ends, with a duplicate pair at each end
    rows.push_back(write_row(0, ELEM_MIN));
    rows.push_back(write_row(1, -5));
    rows.push_back(write_row(2, -5));
    rows.push_back(write_row(3, 7));
    rows.push_back(write_row(pos_t'(TABLE_DEPTH - 3), 100));
    rows.push_back(write_row(pos_t'(TABLE_DEPTH - 2), ELEM_MAX));
    rows.push_back(write_row(pos_t'(TABLE_DEPTH - 1), ELEM_MAX));
    // single-slot ranges at the extremes
    rows.push_back(checked_row(0, 0, ELEM_MIN, 1'b1, 0, 1'b0));
    rows.push_back(checked_row(pos_t'(TABLE_DEPTH - 1), pos_t'(TABLE_DEPTH - 1), ELEM_MAX,
                               1'b1, pos_t'(TABLE_DEPTH - 1), 1'b0));
    // duplicates report the lowest slot
    rows.push_back(checked_row(pos_t'(TABLE_DEPTH - 3), pos_t'(TABLE_DEPTH - 1), ELEM_MAX,
                               1'b1, pos_t'(TABLE_DEPTH - 2), 1'b0));
    rows.push_back(checked_row(0, 3, -5, 1'b1, 1, 1'b0));
    rows.push_back(checked_row(1, 1, -5, 1'b1, 1, 1'b0));
    rows.push_back(checked_row(0, 3, 0, 1'b0, 0, 1'b0));
    rows.push_back(search_row(0, 3, ELEM_MAX));
    rows.push_back(search_row(0, 3, ELEM_MIN));
    // order broken on purpose: the probe sequence decides
    rows.push_back(write_row(2, 50));
    rows.push_back(search_row(0, 3, 50));
    rows.push_back(write_row(pos_t'(TABLE_DEPTH - 4), 1000));
    rows.push_back(search_row(pos_t'(TABLE_DEPTH - 4), pos_t'(TABLE_DEPTH - 1), 100));
    rows.push_back(checked_row(3, 2, 7, 1'b0, 0, 1'b1));
    foreach (rows[i]) drive_beat(rows[i].beat, rows[i].typed, rows[i].answer);

    // fill the lower half in ascending order, so every searched slot is defined
    level = ELEM_MIN;
    for (int s = 0; s < LIVE_SLOTS; s++) begin
      b     = noise_beat();
      b.cmd = CMD_WRITE;
      b.slot = pos_t'(s);
      if (s == LIVE_SLOTS - 1) begin
        level = ELEM_MAX;
      end else if (s > 0 && $urandom_range(3) != 0) begin
        level = level + $urandom_range(16_000_000);
        if (level > ELEM_MAX) level = ELEM_MAX;
      end
      b.element = int'(level);
      send_plain(b);
    end

    // random phases under different idling patterns
    for (int p = 0; p < 5; p++) begin
      send_idle_pct  = phase_send[p];
      recv_stall_pct = phase_recv[p];
      // first phase: long receiver hold-off while the sender keeps offering
      if (p == 0) hold_req <= ~hold_req;
      sent = 0;
      while (sent < PHASE_BEATS) begin
        roll = $urandom_range(99);
        if (roll < 22) begin
          rewrite_run(n);
          sent += n;
        end else if (roll < 25) begin
          b     = noise_beat();
          b.cmd = CMD_WRITE;
          send_plain(b);
          sent++;
        end else begin
          random_search();
          sent++;
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // hard limit on the whole run
  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
